[hdl/line_rasterizer_framebuffer_macros.svh]
// Assertion macros for the line rasterizer framebuffer RTL, included by lrf_ctrl.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef LINE_RASTERIZER_FRAMEBUFFER_MACROS_SVH
`define LINE_RASTERIZER_FRAMEBUFFER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lrf_pkg.sv]
// Shared types and constants for the line rasterizer framebuffer.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package lrf_pkg;

  localparam int PAGE_ROWS = 8;
  localparam int X_W       = 7;
  localparam int Y_W       = 5;
  localparam int ADDR_W    = 9;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 8;
  localparam int ERR_W     = 10;

  localparam logic ACTION_DRAW = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic rd_issue;
    logic publish;
  } lrf_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_point;
  } lrf_status_t;

endpackage

`default_nettype wire

[hdl/lrf_datapath.sv]
// Datapath of the line rasterizer: frame store, Bresenham walker and pixel update pipeline.
// Depends on lrf_pkg; driven by commands from lrf_ctrl.
`default_nettype none

module lrf_datapath #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire lrf_pkg::lrf_cmd_t           cmd,
  output lrf_pkg::lrf_status_t             status,
  input  wire                              action,
  input  wire [lrf_pkg::X_W-1:0]           x_start,
  input  wire [lrf_pkg::Y_W-1:0]           y_start,
  input  wire [lrf_pkg::X_W-1:0]           x_end,
  input  wire [lrf_pkg::Y_W-1:0]           y_end,
  input  wire                              pixel_on,
  input  wire [lrf_pkg::ADDR_W-1:0]        byte_address,
  output logic [lrf_pkg::BYTE_W-1:0]       read_byte,
  output logic [lrf_pkg::CNT_W-1:0]        pixels_written
);

  localparam int PAGES     = (HEIGHT + lrf_pkg::PAGE_ROWS - 1) / lrf_pkg::PAGE_ROWS;
  localparam int STORE_LEN = PAGES * WIDTH;
  localparam int AW        = $clog2(STORE_LEN);
  localparam int EW        = lrf_pkg::ERR_W + 1;

  logic [lrf_pkg::BYTE_W-1:0] mem [STORE_LEN];

  logic                              is_read;
  logic                              pix_on;
  logic [lrf_pkg::ADDR_W-1:0]        rd_addr;
  logic [lrf_pkg::X_W-1:0]           px, px_next, xe;
  logic [lrf_pkg::Y_W-1:0]           py, py_next, ye;
  logic                              sx, sy;
  logic signed [lrf_pkg::ERR_W-1:0]  dx, dy, err, err_next;
  logic [lrf_pkg::CNT_W-1:0]         count;
  logic [AW-1:0]                     clear_cnt;
  logic [lrf_pkg::BYTE_W-1:0]        rd_q;
  logic                              wr_valid;
  logic [AW-1:0]                     wr_idx;
  logic [lrf_pkg::BYTE_W-1:0]        wr_mask;
  logic                              prev_valid;
  logic [AW-1:0]                     prev_idx;
  logic [lrf_pkg::BYTE_W-1:0]        prev_data;

  logic [lrf_pkg::X_W-1:0]           xdiff;
  logic [lrf_pkg::Y_W-1:0]           ydiff;
  logic signed [EW-1:0]              e2;
  logic                              move_x, move_y;
  logic                              pix_in;
  logic [AW-1:0]                     pix_idx;
  logic [lrf_pkg::BYTE_W-1:0]        pix_mask;
  logic [lrf_pkg::BYTE_W-1:0]        base_byte, new_byte;
  logic                              mem_we, mem_re;
  logic [AW-1:0]                     mem_widx, mem_ridx;
  logic [lrf_pkg::BYTE_W-1:0]        mem_wdata;
  logic                              addr_ok;

  assign xdiff = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
  assign ydiff = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);

  assign e2     = {err, 1'b0};
  assign move_x = e2 >= EW'(dy);
  assign move_y = e2 <= EW'(dx);

  always_comb begin
    err_next = err;
    if (move_x) begin
      err_next = err_next + dy;
    end
    if (move_y) begin
      err_next = err_next + dx;
    end
  end

  assign px_next = !move_x ? px : (sx ? px - 1'b1 : px + 1'b1);
  assign py_next = !move_y ? py : (sy ? py - 1'b1 : py + 1'b1);

  assign pix_in   = (9'(px) < 9'(WIDTH)) && (7'(py) < 7'(HEIGHT));
  assign pix_idx  = AW'(AW'(py[lrf_pkg::Y_W-1:3]) * AW'(WIDTH) + AW'(px));
  assign pix_mask = lrf_pkg::BYTE_W'(1) << py[2:0];

  assign base_byte = (prev_valid && prev_idx == wr_idx) ? prev_data : rd_q;
  assign new_byte  = pix_on ? (base_byte | wr_mask) : (base_byte & ~wr_mask);

  assign mem_we    = cmd.clear || wr_valid;
  assign mem_widx  = cmd.clear ? clear_cnt : wr_idx;
  assign mem_wdata = cmd.clear ? '0 : new_byte;
  assign mem_re    = cmd.step || cmd.rd_issue;
  assign mem_ridx  = cmd.rd_issue ? AW'(rd_addr) : pix_idx;

  assign addr_ok = {23'b0, rd_addr} < 32'(STORE_LEN);

  assign status.clear_last = clear_cnt == AW'(STORE_LEN - 1);
  assign status.last_point = (px == xe) && (py == ye);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt  <= '0;
      wr_valid   <= 1'b0;
      prev_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      wr_valid   <= cmd.step && pix_in;
      prev_valid <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read <= action == lrf_pkg::ACTION_READ;
      pix_on  <= pixel_on;
      rd_addr <= byte_address;
      px      <= x_start;
      py      <= y_start;
      xe      <= x_end;
      ye      <= y_end;
      sx      <= !(x_start < x_end);
      sy      <= !(y_start < y_end);
      dx      <= $signed({{(lrf_pkg::ERR_W - lrf_pkg::X_W){1'b0}}, xdiff});
      dy      <= -$signed({{(lrf_pkg::ERR_W - lrf_pkg::Y_W){1'b0}}, ydiff});
      err     <= $signed({{(lrf_pkg::ERR_W - lrf_pkg::X_W){1'b0}}, xdiff})
                 - $signed({{(lrf_pkg::ERR_W - lrf_pkg::Y_W){1'b0}}, ydiff});
      count   <= '0;
    end else if (cmd.step) begin
      px  <= px_next;
      py  <= py_next;
      err <= err_next;
      if (pix_in) begin
        count <= count + 1'b1;
      end
    end
    wr_idx    <= pix_idx;
    wr_mask   <= pix_mask;
    prev_idx  <= wr_idx;
    prev_data <= new_byte;
    if (cmd.publish) begin
      read_byte      <= (is_read && addr_ok) ? rd_q : '0;
      pixels_written <= is_read ? '0 : count;
    end
  end

endmodule

`default_nettype wire

[hdl/lrf_ctrl.sv]
// Controller state machine of the line rasterizer: clearing pass, handshakes and sequencing.
// Depends on lrf_pkg and the assertion macros; commands lrf_datapath.
`default_nettype none

`include "line_rasterizer_framebuffer_macros.svh"

module lrf_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   action,
  output logic                  out_valid,
  input  wire                   out_stall,
  output lrf_pkg::lrf_cmd_t     cmd,
  input  wire lrf_pkg::lrf_status_t status
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DRAW   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (action == lrf_pkg::ACTION_READ) ? S_READ : S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.step = 1'b1;
        if (status.last_point) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_RESULT;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LRF_ASSERT_SAME(a_publish_free, out_valid && out_stall, !cmd.publish, "result overwritten while stalled")
  `LRF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_DRAW || state == S_READ, "accepted item not started")
  `LRF_ASSERT_SAME(a_clear_blocks, state == S_CLEAR, in_stall && !out_valid, "item or result during clearing pass")
  `LRF_ASSERT_NEXT(a_draw_walks, state == S_DRAW && !status.last_point, state == S_DRAW, "line walk cut short")

endmodule

`default_nettype wire

[hdl/line_rasterizer_framebuffer.sv]
// Top level of the line rasterizer over a 1-bit-per-pixel page-layout framebuffer.
// Depends on lrf_pkg, lrf_ctrl and lrf_datapath.
//
// After reset the block clears its frame store, one byte per cycle, all
// ceil(HEIGHT/8)*WIDTH bytes (512 with the default sizes), before the first transfer is
// taken. A draw item walks its line at one pixel per cycle through a read-modify-write
// pipeline on the frame store, then passes a flush state before its result is ready; a
// read item reads its byte from the frame store. One item is in work at a time, and the
// next one may be taken while the previous result still waits in the output register.
`default_nettype none

module line_rasterizer_framebuffer #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           action,
  input  wire [lrf_pkg::X_W-1:0]        x_start,
  input  wire [lrf_pkg::Y_W-1:0]        y_start,
  input  wire [lrf_pkg::X_W-1:0]        x_end,
  input  wire [lrf_pkg::Y_W-1:0]        y_end,
  input  wire                           pixel_on,
  input  wire [lrf_pkg::ADDR_W-1:0]     byte_address,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [lrf_pkg::BYTE_W-1:0]    read_byte,
  output logic [lrf_pkg::CNT_W-1:0]     pixels_written
);

  lrf_pkg::lrf_cmd_t    cmd;
  lrf_pkg::lrf_status_t status;

  lrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lrf_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (action),
    .x_start        (x_start),
    .y_start        (y_start),
    .x_end          (x_end),
    .y_end          (y_end),
    .pixel_on       (pixel_on),
    .byte_address   (byte_address),
    .read_byte      (read_byte),
    .pixels_written (pixels_written)
  );

endmodule

`default_nettype wire
